/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/cptd_pkg.sv */
// ----------------------------------------------------------------------------
// cptd_pkg
// Types, constants and compare helpers for the contact plane dedup block.
// ----------------------------------------------------------------------------
package cptd_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int NTOL_W     = 15;
	localparam int PTOL_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TOL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_XY_TOL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z_TOL  = 2'd2;

	localparam logic [NTOL_W-1:0] NTOL_RESET = 15'd16;
	localparam logic [PTOL_W-1:0] PTOL_RESET = 24'd256;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               walkable;
		logic               penetrating;
	} entry_t;

	typedef struct packed {
		logic [NTOL_W-1:0] normal;
		logic [PTOL_W-1:0] point_xy;
		logic [PTOL_W-1:0] point_z;
	} tol_t;

	function automatic logic within16(logic signed [15:0] a, logic signed [15:0] b,
			logic [NTOL_W-1:0] tol);
		logic signed [16:0] d;
		logic [16:0] mag;
		d   = 17'(a) - 17'(b);
		mag = d[16] ? $unsigned(-d) : $unsigned(d);
		return mag <= {2'b00, tol};
	endfunction

	function automatic logic within32(logic signed [31:0] a, logic signed [31:0] b,
			logic [PTOL_W-1:0] tol);
		logic signed [32:0] d;
		logic [32:0] mag;
		d   = 33'(a) - 33'(b);
		mag = d[32] ? $unsigned(-d) : $unsigned(d);
		return mag <= {9'd0, tol};
	endfunction

endpackage

/* rtl/cptd_if.sv */
// ----------------------------------------------------------------------------
// cptd_if
// Valid/ready channels for incoming planes and emitted table entries.
// ----------------------------------------------------------------------------
interface cptd_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic               is_walkable;
	logic               is_penetrating;
	logic               last_plane;

	modport source (output valid, normal_x, normal_y, normal_z, point_x, point_y, point_z,
		is_walkable, is_penetrating, last_plane, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, point_x, point_y, point_z,
		is_walkable, is_penetrating, last_plane, output ready);
endinterface

interface cptd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_normal_x;
	logic signed [15:0] out_normal_y;
	logic signed [15:0] out_normal_z;
	logic signed [31:0] out_point_x;
	logic signed [31:0] out_point_y;
	logic signed [31:0] out_point_z;
	logic               out_walkable;
	logic               out_penetrating;
	logic               last_entry;
	logic               planes_dropped;

	modport source (output valid, out_normal_x, out_normal_y, out_normal_z, out_point_x,
		out_point_y, out_point_z, out_walkable, out_penetrating, last_entry, planes_dropped,
		input ready);
	modport sink (input valid, out_normal_x, out_normal_y, out_normal_z, out_point_x,
		out_point_y, out_point_z, out_walkable, out_penetrating, last_entry, planes_dropped,
		output ready);
endinterface

/* rtl/cptd_match.sv */
// ----------------------------------------------------------------------------
// cptd_match
// Tolerance compare of one plane against one stored entry.
// ----------------------------------------------------------------------------
module cptd_match (
	input  cptd_pkg::entry_t plane,
	input  cptd_pkg::entry_t entry,
	input  cptd_pkg::tol_t   tol,
	output logic             match
);

	logic n_ok;
	logic p_ok;

	assign n_ok = cptd_pkg::within16(plane.normal_x, entry.normal_x, tol.normal)
		&& cptd_pkg::within16(plane.normal_y, entry.normal_y, tol.normal)
		&& cptd_pkg::within16(plane.normal_z, entry.normal_z, tol.normal);

	assign p_ok = cptd_pkg::within32(plane.point_x, entry.point_x, tol.point_xy)
		&& cptd_pkg::within32(plane.point_y, entry.point_y, tol.point_xy)
		&& cptd_pkg::within32(plane.point_z, entry.point_z, tol.point_z);

	assign match = n_ok && p_ok;

endmodule

/* rtl/contact_plane_tolerance_dedup.sv */
// Scan: a plane is scanned against the stored entries one per cycle through the single
//   table read port; a new plane is accepted only in idle, once that scan (and, on a
//   batch end, the emission of the table) is done.
// Emission: on the last plane of a batch each stored entry is emitted by a table read,
//   then an output register load; output stalls hold it back.
// Reset: entry count, dropped flag, handshakes and tolerances reset; table contents are
//   left undefined and never used before being written.
// ----------------------------------------------------------------------------
// contact_plane_tolerance_dedup
// Merges contact planes within tolerance into a table and emits it per batch.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module contact_plane_tolerance_dedup (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cptd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cptd_pkg::CFG_DATA_W-1:0]      cfg_data,
	cptd_in_if.sink                              in_ch,
	cptd_out_if.source                           out_ch
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_EREAD = 4'b0100,
		ST_ELOAD = 4'b1000
	} state_t;

	state_t state_q;

	cptd_pkg::tol_t   tol_q;
	cptd_pkg::entry_t plane_q;
	logic             last_q;
	logic [cptd_pkg::IDX_W-1:0] idx_q;
	logic [cptd_pkg::CNT_W-1:0] cnt_q;
	logic             dropped_q;

	// table: one write port, one registered read port
	cptd_pkg::entry_t mem [cptd_pkg::TABLE_DEPTH];
	cptd_pkg::entry_t rd_data_q;
	logic             rd_en;
	logic [cptd_pkg::IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [cptd_pkg::IDX_W-1:0] wr_addr;
	cptd_pkg::entry_t wr_data;

	logic             out_valid_q;
	cptd_pkg::entry_t out_entry_q;
	logic             out_last_q;
	logic             out_drop_q;

	logic accept;
	logic match;
	logic hit;
	logic at_end;
	logic scan_done;
	logic has_room;
	logic load;
	logic [cptd_pkg::CNT_W-1:0] idx_next;

	cptd_pkg::entry_t in_plane;
	cptd_pkg::entry_t merged;

	assign in_plane = '{normal_x: in_ch.normal_x, normal_y: in_ch.normal_y,
		normal_z: in_ch.normal_z, point_x: in_ch.point_x, point_y: in_ch.point_y,
		point_z: in_ch.point_z, walkable: in_ch.is_walkable,
		penetrating: in_ch.is_penetrating};

	cptd_match u_match (
		.plane (plane_q),
		.entry (rd_data_q),
		.tol   (tol_q),
		.match (match)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	assign idx_next  = cptd_pkg::CNT_W'(idx_q) + cptd_pkg::CNT_W'(1);
	assign at_end    = (idx_next == cnt_q);
	assign hit       = (cnt_q != '0) && match;
	assign scan_done = (state_q == ST_SCAN) && ((cnt_q == '0) || hit || at_end);
	assign has_room  = (cnt_q < cptd_pkg::CNT_W'(cptd_pkg::TABLE_DEPTH));
	assign load      = (state_q == ST_ELOAD) && (!out_valid_q || out_ch.ready);

	always_comb begin
		merged             = rd_data_q;
		merged.walkable    = rd_data_q.walkable | plane_q.walkable;
		merged.penetrating = rd_data_q.penetrating | plane_q.penetrating;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_en = accept;
			end
			ST_SCAN: begin
				rd_en   = !scan_done;
				rd_addr = idx_next[cptd_pkg::IDX_W-1:0];
			end
			ST_EREAD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
			end
			ST_ELOAD: begin
				rd_en = 1'b0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en   = scan_done && (hit || has_room);
		wr_addr = hit ? idx_q : cnt_q[cptd_pkg::IDX_W-1:0];
		wr_data = hit ? merged : plane_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q.normal   <= cptd_pkg::NTOL_RESET;
			tol_q.point_xy <= cptd_pkg::PTOL_RESET;
			tol_q.point_z  <= cptd_pkg::PTOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cptd_pkg::CFG_NORMAL_TOL:   tol_q.normal   <= cfg_data[cptd_pkg::NTOL_W-1:0];
				cptd_pkg::CFG_POINT_XY_TOL: tol_q.point_xy <= cfg_data;
				cptd_pkg::CFG_POINT_Z_TOL:  tol_q.point_z  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						last_q  <= in_ch.last_plane;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!scan_done) begin
						idx_q <= idx_next[cptd_pkg::IDX_W-1:0];
					end else begin
						if (!hit) begin
							if (has_room) begin
								cnt_q <= cnt_q + cptd_pkg::CNT_W'(1);
							end else begin
								dropped_q <= 1'b1;
							end
						end
						// a batch end always has at least one entry to send
						idx_q   <= '0;
						state_q <= last_q ? ST_EREAD : ST_IDLE;
					end
				end
				ST_EREAD: begin
					state_q <= ST_ELOAD;
				end
				ST_ELOAD: begin
					if (load) begin
						if (at_end) begin
							cnt_q     <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							idx_q   <= idx_next[cptd_pkg::IDX_W-1:0];
							state_q <= ST_EREAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plane_q <= in_plane;
		end
		if (load) begin
			out_entry_q <= rd_data_q;
			out_last_q  <= at_end;
			out_drop_q  <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.out_normal_x    = out_entry_q.normal_x;
	assign out_ch.out_normal_y    = out_entry_q.normal_y;
	assign out_ch.out_normal_z    = out_entry_q.normal_z;
	assign out_ch.out_point_x     = out_entry_q.point_x;
	assign out_ch.out_point_y     = out_entry_q.point_y;
	assign out_ch.out_point_z     = out_entry_q.point_z;
	assign out_ch.out_walkable    = out_entry_q.walkable;
	assign out_ch.out_penetrating = out_entry_q.penetrating;
	assign out_ch.last_entry      = out_last_q;
	assign out_ch.planes_dropped  = out_drop_q;

	`ASSERT_IMPLY(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= cptd_pkg::CNT_W'(cptd_pkg::TABLE_DEPTH))
	`ASSERT_IMPLY(a_drop_full, clk, arst_n, $rose(dropped_q), !has_room)
	`ASSERT_NEXT(a_batch_clear, clk, arst_n, load && at_end, cnt_q == '0 && !dropped_q && out_last_q)
	`ASSERT_IMPLY(a_no_read_write_clash, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr)

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contact plane dedup block: directed planes at the
// field and tolerance extremes, then random batches built from near copies of earlier
// planes and noise planes, checked entry by entry against a local table model.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYC  = 40;
	localparam int HOLD_CYC    = 400;

	typedef struct packed {
		cptd_pkg::entry_t ent;
		logic             last_entry;
		logic             dropped;
	} emit_t;

	typedef longint field_vals_t [10];

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               walk;
		logic               pen;
		logic               last;
		logic               lone;   // single-plane batch: the entry comes back as sent
	} row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [cptd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cptd_pkg::CFG_DATA_W-1:0] cfg_data;

	cptd_in_if  in_ch();
	cptd_out_if out_ch();

	contact_plane_tolerance_dedup DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// table model
	cptd_pkg::entry_t plane_tbl [cptd_pkg::TABLE_DEPTH];
	int             n_kept;
	bit             drop_seen;
	logic [14:0]    tol_normal;
	logic [23:0]    tol_xy;
	logic [23:0]    tol_z;
	emit_t          kept_q [$];

	int             mismatches;
	int             cyc;
	bit             tx_idle_en;
	bit             rx_idle_en;
	bit             hold_go;

	string field_name [10] = '{"out_normal_x", "out_normal_y", "out_normal_z",
		"out_point_x", "out_point_y", "out_point_z", "out_walkable", "out_penetrating",
		"last_entry", "planes_dropped"};

	// reset tolerances: normal 16, xy 256, z 256
	row_t directed_rows [25] = '{
		'{16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			1, 0, 1, 1},
		'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			0, 1, 1, 1},
		// tolerance edges; the closing plane matches entries 0 and 2, first one wins
		'{16384, 0, -16384, 1000, -1000, 0, 0, 0, 0, 0},
		'{16400, 16, -16368, 1256, -1256, 256, 1, 0, 0, 0},
		'{16384, 0, -16367, 1000, -1000, 0, 0, 1, 0, 0},
		'{16384, 0, -16384, 1000, -1000, 257, 0, 0, 0, 0},
		'{16384, 0, -16384, 1000, -1000, 128, 0, 1, 1, 0},
		// fill the table, drop one, merge into a full table on the batch end
		'{-32768, 0, 0, 0, 0, 0, 1, 1, 0, 0},
		'{0, 0, 0, 'h10000, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 'h20000, 0, 0, 1, 0, 0, 0},
		'{0, 0, 0, 'h30000, 0, 0, 0, 1, 0, 0},
		'{0, 0, 0, 'h40000, 0, 0, 1, 1, 0, 0},
		'{0, 0, 0, 'h50000, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 'h60000, 0, 0, 1, 0, 0, 0},
		'{0, 0, 0, 'h70000, 0, 0, 0, 1, 0, 0},
		'{0, 0, 0, 'h80000, 0, 0, 1, 1, 0, 0},
		'{0, 0, 0, 'h90000, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 'hA0000, 0, 0, 1, 0, 0, 0},
		'{0, 0, 0, 'hB0000, 0, 0, 0, 1, 0, 0},
		'{0, 0, 0, 'hC0000, 0, 0, 1, 1, 0, 0},
		'{0, 0, 0, 'hD0000, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 'hE0000, 0, 0, 1, 0, 0, 0},
		'{0, 0, 0, 'hF0000, 0, 0, 0, 1, 0, 0},
		'{32767, 0, 0, 0, 0, 0, 1, 1, 0, 0},
		'{0, 0, 0, 'h50064, 0, 0, 1, 1, 1, 0}
	};

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic bit near(longint a, longint b, longint lim);
		longint d;
		d = a - b;
		if (d < 0)
			d = -d;
		return d <= lim;
	endfunction

	function automatic bit same_plane(cptd_pkg::entry_t s, cptd_pkg::entry_t p);
		return near(s.normal_x, p.normal_x, tol_normal) &&
			near(s.normal_y, p.normal_y, tol_normal) &&
			near(s.normal_z, p.normal_z, tol_normal) &&
			near(s.point_x, p.point_x, tol_xy) &&
			near(s.point_y, p.point_y, tol_xy) &&
			near(s.point_z, p.point_z, tol_z);
	endfunction

	function automatic void absorb_plane(cptd_pkg::entry_t p, bit last, ref emit_t outs[$]);
		int hit;
		hit = -1;
		for (int i = 0; i < n_kept; i++)
			if (hit < 0 && same_plane(plane_tbl[i], p))
				hit = i;
		if (hit >= 0) begin
			plane_tbl[hit].walkable    = plane_tbl[hit].walkable | p.walkable;
			plane_tbl[hit].penetrating = plane_tbl[hit].penetrating | p.penetrating;
		end else if (n_kept < cptd_pkg::TABLE_DEPTH) begin
			plane_tbl[n_kept] = p;
			n_kept++;
		end else begin
			drop_seen = 1'b1;
		end
		if (last) begin
			for (int i = 0; i < n_kept; i++)
				outs.insert(outs.size(), emit_t'{plane_tbl[i], i == n_kept - 1, drop_seen});
			n_kept    = 0;
			drop_seen = 1'b0;
		end
	endfunction

	function automatic field_vals_t flatten(emit_t e);
		return '{e.ent.normal_x, e.ent.normal_y, e.ent.normal_z, e.ent.point_x,
			e.ent.point_y, e.ent.point_z, e.ent.walkable, e.ent.penetrating,
			e.last_entry, e.dropped};
	endfunction

	// field values with a bias toward min, max, zero and all ones
	function automatic logic [31:0] wild(int w);
		case ($urandom_range(0, 7))
			0: return 32'd1 << (w - 1);
			1: return (32'd1 << (w - 1)) - 1;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// offset around the tolerance edge, either direction
	function automatic logic [31:0] nudge(logic [31:0] v, int unsigned lim);
		int unsigned mag;
		case ($urandom_range(0, 4))
			1: mag = lim;
			2: mag = lim + 1;
			3: mag = $urandom_range(0, lim + 1);
			default: mag = 0;
		endcase
		return $urandom_range(0, 1) ? v + mag : v - mag;
	endfunction

	task automatic push_plane(cptd_pkg::entry_t p, bit last, bit lone);
		emit_t outs[$];
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.normal_x       <= p.normal_x;
		in_ch.normal_y       <= p.normal_y;
		in_ch.normal_z       <= p.normal_z;
		in_ch.point_x        <= p.point_x;
		in_ch.point_y        <= p.point_y;
		in_ch.point_z        <= p.point_z;
		in_ch.is_walkable    <= p.walkable;
		in_ch.is_penetrating <= p.penetrating;
		in_ch.last_plane     <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		absorb_plane(p, last, outs);
		if (lone)
			kept_q.insert(kept_q.size(), emit_t'{p, 1'b1, 1'b0});
		else
			foreach (outs[i])
				kept_q.insert(kept_q.size(), outs[i]);
	endtask

	task automatic settle();
		while (kept_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [cptd_pkg::CFG_IDX_W-1:0] idx,
			logic [cptd_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_tolerances(logic [14:0] nt, logic [23:0] xy, logic [23:0] z);
		settle();
		// upper bits of the normal register are don't-care
		write_reg(cptd_pkg::CFG_NORMAL_TOL, {9'($urandom), nt});
		write_reg(cptd_pkg::CFG_POINT_XY_TOL, xy);
		write_reg(cptd_pkg::CFG_POINT_Z_TOL, z);
		cfg_we     <= 1'b0;
		tol_normal = nt;
		tol_xy     = xy;
		tol_z      = z;
	endtask

	task automatic run_directed();
		cptd_pkg::entry_t p;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		foreach (directed_rows[i]) begin
			p.normal_x    = directed_rows[i].nx;
			p.normal_y    = directed_rows[i].ny;
			p.normal_z    = directed_rows[i].nz;
			p.point_x     = directed_rows[i].px;
			p.point_y     = directed_rows[i].py;
			p.point_z     = directed_rows[i].pz;
			p.walkable    = directed_rows[i].walk;
			p.penetrating = directed_rows[i].pen;
			push_plane(p, directed_rows[i].last, directed_rows[i].lone);
		end
		in_ch.valid <= 1'b0;
	endtask

	// batches of near copies with random content, plus noise planes;
	// long batches are mostly noise so the table overflows now and then
	task automatic run_batches(int n_items, bit may_idle);
		cptd_pkg::entry_t made[$];
		cptd_pkg::entry_t p;
		cptd_pkg::entry_t b;
		int len;
		int near_odds;
		int done;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(0, 5) == 0) begin
				len       = $urandom_range(17, 24);
				near_odds = 1;
			end else begin
				len       = $urandom_range(1, 8);
				near_odds = 3;
			end
			tx_idle_en = may_idle && $urandom_range(0, 2) != 0;
			rx_idle_en = may_idle && $urandom_range(0, 2) != 0;
			made.delete();
			for (int k = 0; k < len; k++) begin
				if (made.size() != 0 && $urandom_range(0, 3) < near_odds) begin
					b = made[$urandom_range(0, made.size() - 1)];
					p.normal_x = 16'(nudge(b.normal_x, tol_normal));
					p.normal_y = 16'(nudge(b.normal_y, tol_normal));
					p.normal_z = 16'(nudge(b.normal_z, tol_normal));
					p.point_x  = nudge(b.point_x, tol_xy);
					p.point_y  = nudge(b.point_y, tol_xy);
					p.point_z  = nudge(b.point_z, tol_z);
				end else begin
					p.normal_x = 16'(wild(16));
					p.normal_y = 16'(wild(16));
					p.normal_z = 16'(wild(16));
					p.point_x  = wild(32);
					p.point_y  = wild(32);
					p.point_z  = wild(32);
				end
				p.walkable    = 1'($urandom_range(0, 1));
				p.penetrating = 1'($urandom_range(0, 1));
				made.insert(made.size(), p);
				push_plane(p, k == len - 1, 1'b0);
			end
			done += len;
		end
		in_ch.valid <= 1'b0;
	endtask

	task automatic check_result(emit_t got);
		field_vals_t want_v;
		field_vals_t got_v;
		if (kept_q.size() == 0) begin
			mismatches++;
			$display("%0t: entry emitted with none pending, got %p", $time, flatten(got));
		end else begin
			want_v = flatten(kept_q.pop_front());
			got_v  = flatten(got);
			foreach (want_v[i])
				if (want_v[i] != got_v[i]) begin
					mismatches++;
					$display("%0t: %s expected %0d got %0d", $time, field_name[i],
						want_v[i], got_v[i]);
				end
		end
	endtask

	always @(posedge clk) begin : watch_out
		emit_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.ent.normal_x    = out_ch.out_normal_x;
			got.ent.normal_y    = out_ch.out_normal_y;
			got.ent.normal_z    = out_ch.out_normal_z;
			got.ent.point_x     = out_ch.out_point_x;
			got.ent.point_y     = out_ch.out_point_y;
			got.ent.point_z     = out_ch.out_point_z;
			got.ent.walkable    = out_ch.out_walkable;
			got.ent.penetrating = out_ch.out_penetrating;
			got.last_entry      = out_ch.last_entry;
			got.dropped         = out_ch.planes_dropped;
			check_result(got);
		end
	end

	// receiver: random stalls, plus one long hold to back the block up
	initial begin : rx_side
		bit held;
		held = 1'b0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_go && !held) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		mismatches           = 0;
		n_kept               = 0;
		drop_seen            = 1'b0;
		tol_normal           = cptd_pkg::NTOL_RESET;
		tol_xy               = cptd_pkg::PTOL_RESET;
		tol_z                = cptd_pkg::PTOL_RESET;
		tx_idle_en           = 1'b0;
		rx_idle_en           = 1'b0;
		hold_go              = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		in_ch.valid          = 1'b0;
		in_ch.normal_x       = '0;
		in_ch.normal_y       = '0;
		in_ch.normal_z       = '0;
		in_ch.point_x        = '0;
		in_ch.point_y        = '0;
		in_ch.point_z        = '0;
		in_ch.is_walkable    = 1'b0;
		in_ch.is_penetrating = 1'b0;
		in_ch.last_plane     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();

		// exact match only
		set_tolerances(15'd0, 24'd0, 24'd0);
		run_batches(45, 1'b1);
		// widest tolerances
		set_tolerances(15'h7FFF, 24'hFFFFFF, 24'hFFFFFF);
		run_batches(45, 1'b1);
		set_tolerances(15'($urandom_range(0, 400)), 24'($urandom_range(0, 100000)),
			24'($urandom));
		run_batches(45, 1'b1);
		set_tolerances(15'd16, 24'd256, 24'd256);
		hold_go = 1'b1;
		run_batches(45, 1'b1);
		// closing stretch without idling
		set_tolerances(15'd100, 24'd5000, 24'd70);
		run_batches(45, 1'b0);

		settle();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
